>>> sv/fuc_pkg.sv
// fuc_pkg: shared types and constants for the first unique character finder
// no dependencies

package fuc_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 6;
    localparam int SEEN_W = 2;
    localparam int ALPHABET = 1 << CHAR_W;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [SEEN_W-1:0] t_seen;

    // occurrence count codes, saturating at "two or more"
    localparam t_seen SEEN_NONE = 2'd0;
    localparam t_seen SEEN_ONCE = 2'd1;
    localparam t_seen SEEN_MANY = 2'd2;

endpackage

>>> sv/first_unique_char_finder_core.sv
// first_unique_char_finder_core: reports the index of the first byte value
// that occurs exactly once in a string; depends on fuc_pkg

// Bytes of a string are taken one per cycle while the block is idle, each
// appended to a string memory of CAPACITY entries, and the per-value
// occurrence count in a 256-entry count memory is updated by a one-stage
// read-modify-write with forwarding, so equal consecutive bytes count
// correctly. Bytes beyond CAPACITY are dropped and flagged as overflow.
// After the transaction marked last, the block scans the stored string in a
// two-read pipeline (string memory, then count memory) and stops at the first
// byte whose count is one or at the end of the stored string; input is
// accepted again as soon as the result enters the output register.
// Counts are cleared at once through per-entry valid bits when the result
// is loaded, so no clearing pass is needed. Position carries the low six
// bits of the index when CAPACITY exceeds 64.

module first_unique_char_finder_core #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fuc_pkg::t_char       i_character,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fuc_pkg::t_pos        o_position,
    output logic                 o_found,
    output logic                 o_overflow
);

    localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    t_state r_state;

    // string memory and occurrence count memory
    fuc_pkg::t_char r_cmem [CAPACITY];
    fuc_pkg::t_seen r_smem [fuc_pkg::ALPHABET];
    logic [fuc_pkg::ALPHABET-1:0] r_vbit;

    logic [TW-1:0]  r_total;
    logic           r_dropped;

    // count update stage
    logic           r_s1_vld;
    fuc_pkg::t_char r_s1_ch;
    logic           r_fw_vld;
    fuc_pkg::t_char r_fw_ch;
    fuc_pkg::t_seen r_fw_cnt;

    // count memory read data
    fuc_pkg::t_seen r_rd;
    logic           r_rd_vld;

    // scan pipeline
    logic [KW-1:0]  r_k;
    logic           r_issue;
    logic           r_p1_vld;
    logic [KW-1:0]  r_p1_idx;
    fuc_pkg::t_char r_cdata;
    logic           r_p2_vld;
    logic [KW-1:0]  r_p2_idx;

    // pending result and output register
    fuc_pkg::t_pos  r_res_pos;
    logic           r_res_found;
    logic           r_o_valid;
    fuc_pkg::t_pos  r_o_position;
    logic           r_o_found;
    logic           r_o_overflow;

    logic           in_acc;
    logic           has_room;
    logic [TW-1:0]  total_m1;
    fuc_pkg::t_char rd_addr;
    fuc_pkg::t_seen old_cnt;
    fuc_pkg::t_seen n_cnt;
    logic           scan_hit;
    logic           scan_end;
    logic           out_free;

    assign o_ready    = (r_state == ST_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign has_room   = (r_total < TW'(CAPACITY));
    assign total_m1   = r_total - TW'(1);
    assign rd_addr    = (r_state == ST_IDLE) ? i_character : r_cdata;
    assign out_free   = !r_o_valid || i_ready;

    assign o_valid    = r_o_valid;
    assign o_position = r_o_position;
    assign o_found    = r_o_found;
    assign o_overflow = r_o_overflow;

    always_comb begin
        if (r_fw_vld && (r_fw_ch == r_s1_ch)) begin
            old_cnt = r_fw_cnt;
        end else if (r_rd_vld) begin
            old_cnt = r_rd;
        end else begin
            old_cnt = fuc_pkg::SEEN_NONE;
        end
        if (old_cnt >= fuc_pkg::SEEN_MANY) begin
            n_cnt = fuc_pkg::SEEN_MANY;
        end else begin
            n_cnt = old_cnt + fuc_pkg::SEEN_ONCE;
        end
    end

    assign scan_hit = r_p2_vld && r_rd_vld && (r_rd == fuc_pkg::SEEN_ONCE);
    assign scan_end = r_p2_vld && (TW'(r_p2_idx) == total_m1);

    // string memory: append port and scan read port
    always_ff @(posedge i_clk) begin
        if (in_acc && has_room) begin
            r_cmem[r_total[KW-1:0]] <= i_character;
        end
        r_cdata <= r_cmem[r_k];
    end

    // count memory: update write port and shared read port
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_smem[r_s1_ch] <= n_cnt;
        end
        r_rd <= r_smem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_vbit    <= '0;
            r_total   <= '0;
            r_dropped <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_fw_vld  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_k       <= '0;
            r_issue   <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_vld <= r_vbit[rd_addr];
            r_s1_vld <= in_acc && has_room;
            r_s1_ch  <= i_character;
            r_fw_vld <= r_s1_vld;
            r_fw_ch  <= r_s1_ch;
            r_fw_cnt <= n_cnt;
            if (r_s1_vld) begin
                r_vbit[r_s1_ch] <= 1'b1;
            end

            r_p1_vld <= (r_state == ST_SCAN) && r_issue;
            r_p1_idx <= r_k;
            r_p2_vld <= (r_state == ST_SCAN) && r_p1_vld;
            r_p2_idx <= r_p1_idx;

            // in drain an accepted result is replaced by the next one below
            if (r_o_valid && i_ready && (r_state != ST_DRAIN)) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (has_room) begin
                            r_total <= r_total + TW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last) begin
                            r_k     <= '0;
                            r_issue <= 1'b1;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_hit || scan_end) begin
                        r_res_found <= scan_hit;
                        r_res_pos   <= scan_hit ? fuc_pkg::POS_W'(r_p2_idx) : '0;
                        r_issue     <= 1'b0;
                        r_state     <= ST_DRAIN;
                    end else if (r_issue) begin
                        if (TW'(r_k) == total_m1) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (out_free) begin
                        r_o_valid    <= 1'b1;
                        r_o_position <= r_res_pos;
                        r_o_found    <= r_res_found;
                        r_o_overflow <= r_dropped;
                        r_vbit       <= '0;
                        r_total      <= '0;
                        r_dropped    <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_total_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(CAPACITY))
        else $error("string length beyond capacity");

    a_last_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> (r_state == ST_SCAN))
        else $error("last transaction did not start the scan");

    a_result_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == ST_DRAIN))
        else $error("result loaded outside drain");

    a_no_update_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> !r_s1_vld)
        else $error("count update overlaps scan read");
`endif

endmodule

>>> verif/testbench.sv
// testbench for first_unique_char_finder_core: random and directed strings,
// checked against a behavioral predictor of the first unique byte search
// depends on fuc_pkg and first_unique_char_finder_core
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY    = 64;
    localparam int BYTE_TARGET = 1800;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_GAP     = 18;

    typedef struct {
        fuc_pkg::t_char ch;
        logic           last;
        int unsigned    gap;
    } t_str_byte;

    typedef struct {
        fuc_pkg::t_pos pos;
        logic          found;
        logic          ovf;
    } t_scan_result;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    fuc_pkg::t_char i_character = '0;
    logic           i_last = 1'b0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    fuc_pkg::t_pos  o_position;
    logic           o_found;
    logic           o_overflow;

    first_unique_char_finder_core #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_character(i_character),
        .i_last(i_last),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_position(o_position),
        .o_found(o_found),
        .o_overflow(o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: the string as the block stores it
    fuc_pkg::t_char str_mem [CAPACITY];
    int unsigned    str_len;
    fuc_pkg::t_seen seen_tab [fuc_pkg::ALPHABET];
    logic           lost_bytes;
    t_scan_result   result_q [$];

    t_str_byte    byte_q [$];
    int unsigned  total_bytes;
    int unsigned  bytes_sent;
    int unsigned  strings_done;
    int unsigned  found_cnt;
    int unsigned  ovf_cnt;
    int unsigned  results_seen;
    int unsigned  err_cnt;
    int unsigned  cycle_cnt;
    int unsigned  feed_quiet;
    int unsigned  drain_quiet;

    function automatic void clear_string();
        str_len = 0;
        lost_bytes = 1'b0;
        foreach (seen_tab[v]) seen_tab[v] = fuc_pkg::SEEN_NONE;
    endfunction

    // apply one accepted byte; the last byte of a string yields the search result
    function automatic void take_byte(input fuc_pkg::t_char ch, input logic is_last);
        int k;
        t_scan_result r;
        if (str_len < CAPACITY) begin
            str_mem[str_len] = ch;
            str_len++;
            seen_tab[ch] = (seen_tab[ch] == fuc_pkg::SEEN_NONE) ? fuc_pkg::SEEN_ONCE :
                           fuc_pkg::SEEN_MANY;
        end else begin
            lost_bytes = 1'b1;
        end
        if (is_last) begin
            r.pos = '0;
            r.found = 1'b0;
            r.ovf = lost_bytes;
            for (k = 0; k < int'(str_len); k++) begin
                if (!r.found && seen_tab[str_mem[k]] == fuc_pkg::SEEN_ONCE) begin
                    r.pos = fuc_pkg::t_pos'(k);
                    r.found = 1'b1;
                end
            end
            result_q.push_back(r);
            strings_done++;
            if (r.found) found_cnt++;
            if (r.ovf) ovf_cnt++;
            clear_string();
        end
    endfunction

    // idle draw with occasional stretches of back-to-back traffic
    function automatic int unsigned pick_gap(inout int unsigned quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0) quiet = $urandom_range(20, 80);
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void push_byte(input fuc_pkg::t_char ch, input logic is_last);
        t_str_byte b;
        b.ch = ch;
        b.last = is_last;
        b.gap = pick_gap(feed_quiet);
        byte_q.push_back(b);
        total_bytes++;
    endfunction

    // random string; style picks how repeats and unique bytes are arranged
    function automatic void push_random_string();
        int unsigned len;
        int unsigned style;
        int unsigned uniq_at;
        int unsigned alph;
        int unsigned k;
        fuc_pkg::t_char base;
        fuc_pkg::t_char uniq;
        fuc_pkg::t_char fill_a;
        fuc_pkg::t_char fill_b;
        fuc_pkg::t_char ch;
        style = $urandom_range(0, 9);
        len = (style >= 8) ? $urandom_range(CAPACITY - 4, CAPACITY + 16) :
              $urandom_range(1, 16);
        if (style == 7) len = $urandom_range(2, CAPACITY);
        alph = $urandom_range(1, 5);
        base = fuc_pkg::t_char'($urandom_range(0, 255));
        uniq = fuc_pkg::t_char'($urandom_range(0, 255));
        fill_a = uniq + fuc_pkg::t_char'($urandom_range(1, 100));
        fill_b = fill_a + 8'd1;
        uniq_at = $urandom_range(0, len - 1);
        for (k = 0; k < len; k++) begin
            case (style)
                0, 1, 2, 9: ch = fuc_pkg::t_char'($urandom_range(0, 255));
                3, 4, 5:    ch = base + fuc_pkg::t_char'($urandom_range(0, alph - 1));
                default: begin
                    // planted unique byte among repeated filler
                    if (k == uniq_at) ch = uniq;
                    else ch = (k[0]) ? fill_b : fill_a;
                end
            endcase
            push_byte(ch, k == len - 1);
        end
    endfunction

    // driver
    bit          drv_free;
    int unsigned drv_wait;
    t_str_byte   cur_byte;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_wait = 0;
        end else begin
            drv_free = !i_valid;
            if (i_valid && o_ready) begin
                take_byte(i_character, i_last);
                bytes_sent++;
                drv_free = 1'b1;
            end
            if (drv_free) begin
                if (byte_q.size() != 0 && drv_wait < byte_q[0].gap) begin
                    drv_wait++;
                    i_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    cur_byte = byte_q.pop_front();
                    drv_wait = 0;
                    i_character <= cur_byte.ch;
                    i_last <= cur_byte.last;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int unsigned  rdy_hold;
    t_scan_result want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    $error("result transaction with nothing expected: position %0d found %0b",
                           o_position, o_found);
                    err_cnt++;
                end else begin
                    want = result_q.pop_front();
                    if (o_position !== want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, o_position);
                        err_cnt++;
                    end
                    if (o_found !== want.found) begin
                        $error("found: expected %0b, got %0b", want.found, o_found);
                        err_cnt++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $error("overflow: expected %0b, got %0b", want.ovf, o_overflow);
                        err_cnt++;
                    end
                end
                rdy_hold = pick_gap(drain_quiet);
            end else if (rdy_hold > 0) begin
                rdy_hold--;
            end
            i_ready <= (rdy_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_cnt, result_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        clear_string();
        rdy_hold = 0;

        // single byte strings at both ends of the byte range
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // two equal bytes: nothing unique
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b1);
        // unique byte in the middle
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b1);
        // equal consecutive bytes, unique byte last
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
        // all values repeated
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        // alternating bit patterns, unique at the tail
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h01, 1'b1);

        while (total_bytes < BYTE_TARGET) push_random_string();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_sent != total_bytes) @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
        // a full scan plus margin, to catch any stray result
        repeat (CAPACITY + 20) @(posedge i_clk);

        $display("%0d bytes in %0d strings, %0d results checked", bytes_sent, strings_done,
                 results_seen);
        $display("%0d strings had a unique byte, %0d overflowed the store", found_cnt, ovf_cnt);
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> first_unique_char_finder_core.f
sv/fuc_pkg.sv
sv/first_unique_char_finder_core.sv
verif/testbench.sv
